FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: sv/sit_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection test package
// Widths, stream layout and case codes shared by the intersection pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int DELTA_W     = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * DELTA_W;
	localparam int DEN_W       = PROD_W + 1;
	localparam int WIDE_W      = PROD_W + DELTA_W + 2;

	localparam int IN_FIELDS   = 8;
	localparam int IN_TDATA_W  = ((IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_BITS    = 4;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [2:0] {
		CASE_VH   = 3'd0,
		CASE_HV   = 3'd1,
		CASE_X    = 3'd2,
		CASE_Y    = 3'd3,
		CASE_NONE = 3'd4
	} case_t;

endpackage

FILE: sv/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// Segment intersection test
// Five pipeline stages from input transfer to result; one segment pair per cycle
// unless a receiver stall fills them; a full stage holds while its successor stalls.
// Asynchronous active-low reset empties the pipeline; no other state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_test (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  logic [sit_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// crosses [0], case_taken [3:1], zero pad
	output logic [sit_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import sit_pkg::*;

	localparam int W = COORD_WIDTH;

	typedef logic signed [W-1:0]       coord_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [DEN_W-1:0]   den_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !v_s5 || m_axis_tready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: deltas, ranges, case ----------------
	coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	case_t  case_in;

	assign ax0 = coord_t'(s_axis_tdata[0*W +: W]);
	assign ay0 = coord_t'(s_axis_tdata[1*W +: W]);
	assign ax1 = coord_t'(s_axis_tdata[2*W +: W]);
	assign ay1 = coord_t'(s_axis_tdata[3*W +: W]);
	assign bx0 = coord_t'(s_axis_tdata[4*W +: W]);
	assign by0 = coord_t'(s_axis_tdata[5*W +: W]);
	assign bx1 = coord_t'(s_axis_tdata[6*W +: W]);
	assign by1 = coord_t'(s_axis_tdata[7*W +: W]);

	always_comb begin
		priority if (ax0 == ax1 && by0 == by1) case_in = CASE_VH;
		else if (ay0 == ay1 && bx0 == bx1)     case_in = CASE_HV;
		else if (ax0 != ax1 && bx0 != bx1)     case_in = CASE_X;
		else if (ay0 != ay1 && by0 != by1)     case_in = CASE_Y;
		else                                   case_in = CASE_NONE;
	end

	coord_t ax0_s1, ay0_s1, bx0_s1, by0_s1;
	delta_t dxa_s1, dya_s1, dxb_s1, dyb_s1;
	coord_t xmina_s1, xmaxa_s1, ymina_s1, ymaxa_s1;
	coord_t xminb_s1, xmaxb_s1, yminb_s1, ymaxb_s1;
	case_t  case_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			ax0_s1   <= ax0;
			ay0_s1   <= ay0;
			bx0_s1   <= bx0;
			by0_s1   <= by0;
			dxa_s1   <= delta_t'(ax0) - delta_t'(ax1);
			dya_s1   <= delta_t'(ay0) - delta_t'(ay1);
			dxb_s1   <= delta_t'(bx0) - delta_t'(bx1);
			dyb_s1   <= delta_t'(by0) - delta_t'(by1);
			xmina_s1 <= (ax0 < ax1) ? ax0 : ax1;
			xmaxa_s1 <= (ax0 > ax1) ? ax0 : ax1;
			ymina_s1 <= (ay0 < ay1) ? ay0 : ay1;
			ymaxa_s1 <= (ay0 > ay1) ? ay0 : ay1;
			xminb_s1 <= (bx0 < bx1) ? bx0 : bx1;
			xmaxb_s1 <= (bx0 > bx1) ? bx0 : bx1;
			yminb_s1 <= (by0 < by1) ? by0 : by1;
			ymaxb_s1 <= (by0 > by1) ? by0 : by1;
			case_s1  <= case_in;
		end
	end

	// ---------------- stage 2: axis select, first products ----------------
	logic   axis_y;
	coord_t u1, v1, u2, v2;
	delta_t du1, dv1, du2, dv2, dvv;
	coord_t umin1, umax1, umin2, umax2;
	logic   hit_axis_free;

	assign axis_y = (case_s1 == CASE_Y);
	assign u1     = axis_y ? ay0_s1 : ax0_s1;
	assign v1     = axis_y ? ax0_s1 : ay0_s1;
	assign u2     = axis_y ? by0_s1 : bx0_s1;
	assign v2     = axis_y ? bx0_s1 : by0_s1;
	assign du1    = axis_y ? dya_s1 : dxa_s1;
	assign dv1    = axis_y ? dxa_s1 : dya_s1;
	assign du2    = axis_y ? dyb_s1 : dxb_s1;
	assign dv2    = axis_y ? dxb_s1 : dyb_s1;
	assign umin1  = axis_y ? ymina_s1 : xmina_s1;
	assign umax1  = axis_y ? ymaxa_s1 : xmaxa_s1;
	assign umin2  = axis_y ? yminb_s1 : xminb_s1;
	assign umax2  = axis_y ? ymaxb_s1 : xmaxb_s1;
	assign dvv    = delta_t'(v1) - delta_t'(v2);

	always_comb begin
		unique case (case_s1)
			CASE_VH: hit_axis_free = (xmaxa_s1 < xmaxb_s1) && (xmaxa_s1 > xminb_s1) &&
				(ymaxb_s1 < ymaxa_s1) && (ymaxb_s1 > ymina_s1);
			CASE_HV: hit_axis_free = (xmaxb_s1 < xmaxa_s1) && (xmaxb_s1 > xmina_s1) &&
				(ymaxa_s1 < ymaxb_s1) && (ymaxa_s1 > yminb_s1);
			default: hit_axis_free = 1'b0;
		endcase
	end

	prod_t  p1_s2, p2_s2, q_s2;
	delta_t du2_s2;
	coord_t u1_s2, u2_s2;
	coord_t umin1_s2, umax1_s2, umin2_s2, umax2_s2;
	case_t  case_s2;
	logic   hit0_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			p1_s2    <= prod_t'(dv1) * prod_t'(du2);
			p2_s2    <= prod_t'(dv2) * prod_t'(du1);
			q_s2     <= prod_t'(dvv) * prod_t'(du1);
			du2_s2   <= du2;
			u1_s2    <= u1;
			u2_s2    <= u2;
			umin1_s2 <= umin1;
			umax1_s2 <= umax1;
			umin2_s2 <= umin2;
			umax2_s2 <= umax2;
			case_s2  <= case_s1;
			hit0_s2  <= hit_axis_free;
		end
	end

	// ---------------- stage 3: denominator, triple products ----------------
	den_t   den_s3;
	wide_t  t1_s3, t2_s3, t3_s3;
	coord_t umin1_s3, umax1_s3, umin2_s3, umax2_s3;
	case_t  case_s3;
	logic   hit0_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			den_s3   <= den_t'(p1_s2) - den_t'(p2_s2);
			t1_s3    <= wide_t'(q_s2) * wide_t'(du2_s2);
			t2_s3    <= wide_t'(p1_s2) * wide_t'(u1_s2);
			t3_s3    <= wide_t'(p2_s2) * wide_t'(u2_s2);
			umin1_s3 <= umin1_s2;
			umax1_s3 <= umax1_s2;
			umin2_s3 <= umin2_s2;
			umax2_s3 <= umax2_s2;
			case_s3  <= case_s2;
			hit0_s3  <= hit0_s2;
		end
	end

	// ---------------- stage 4: numerator, scaled bounds ----------------
	wide_t num_s4, lo1_s4, hi1_s4, lo2_s4, hi2_s4;
	logic  dneg_s4, dzero_s4;
	case_t case_s4;
	logic  hit0_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			num_s4   <= t2_s3 - t1_s3 - t3_s3;
			lo1_s4   <= wide_t'(den_s3) * wide_t'(umin1_s3);
			hi1_s4   <= wide_t'(den_s3) * wide_t'(umax1_s3);
			lo2_s4   <= wide_t'(den_s3) * wide_t'(umin2_s3);
			hi2_s4   <= wide_t'(den_s3) * wide_t'(umax2_s3);
			dneg_s4  <= den_s3[DEN_W-1];
			dzero_s4 <= (den_s3 == '0);
			case_s4  <= case_s3;
			hit0_s4  <= hit0_s3;
		end
	end

	// ---------------- stage 5: range compares, output register ----------------
	logic in1, in2, hit;

	always_comb begin
		if (dneg_s4) begin
			in1 = (lo1_s4 > num_s4) && (num_s4 > hi1_s4);
			in2 = (lo2_s4 > num_s4) && (num_s4 > hi2_s4);
		end else begin
			in1 = (lo1_s4 < num_s4) && (num_s4 < hi1_s4);
			in2 = (lo2_s4 < num_s4) && (num_s4 < hi2_s4);
		end
		if (case_s4 == CASE_X || case_s4 == CASE_Y) begin
			hit = !dzero_s4 && in1 && in2;
		end else begin
			hit = hit0_s4;
		end
	end

	logic  crosses_s5;
	case_t case_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			crosses_s5 <= hit;
			case_s5    <= case_s4;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, case_s5, crosses_s5};

	// ---------------- assertions ----------------
	`ASSERT_IMPL(a_none_no_cross, clk, arst_n, v_s5 && case_s5 == CASE_NONE, !crosses_s5)
	`ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, !s_axis_tready, v_s1 && v_s5)
	`ASSERT_NEXT(a_accept_enters_s1, clk, arst_n, s_axis_tvalid && s_axis_tready, v_s1)
	`ASSERT_IMPL(a_case_legal, clk, arst_n, v_s5,
		case_s5 == CASE_VH || case_s5 == CASE_HV || case_s5 == CASE_X ||
		case_s5 == CASE_Y || case_s5 == CASE_NONE)

endmodule

FILE: tb/crossing_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment crossing checker
// Watches both stream channels of the intersection block, predicts the
// crossing flag and case code of every accepted segment pair with exact
// wide integer arithmetic, and compares each result transfer in order.
// ----------------------------------------------------------------------------
module crossing_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [sit_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [sit_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output int                              fail_count,
	output int                              pending
);
	import sit_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic  crosses;
		case_t case_taken;
	} crossing_t;

	crossing_t expected_crossings[$];
	int        fails = 0;

	// crossing coordinate num/den strictly inside both ranges along axis u
	function automatic logic crosses_on_axis(
		wide_t u1, wide_t v1, wide_t du1, wide_t dv1,
		wide_t u2, wide_t v2, wide_t du2, wide_t dv2,
		wide_t umin1, wide_t umax1, wide_t umin2, wide_t umax2
	);
		wide_t den;
		wide_t num;
		den = dv1 * du2 - dv2 * du1;
		num = -((v1 - v2) * du1 * du2) + dv1 * du2 * u1 - dv2 * du1 * u2;
		if (den == 0)
			return 1'b0;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		return (den * umin1 < num) && (num < den * umax1) &&
			(den * umin2 < num) && (num < den * umax2);
	endfunction

	function automatic crossing_t predict_crossing(logic [IN_TDATA_W-1:0] d);
		wide_t     c[8];
		wide_t     ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		wide_t     dxa, dya, dxb, dyb;
		wide_t     xmina, xmaxa, ymina, ymaxa, xminb, xmaxb, yminb, ymaxb;
		crossing_t r;
		for (int i = 0; i < 8; i++)
			c[i] = wide_t'($signed(d[COORD_WIDTH*i +: COORD_WIDTH]));
		ax0 = c[0]; ay0 = c[1]; ax1 = c[2]; ay1 = c[3];
		bx0 = c[4]; by0 = c[5]; bx1 = c[6]; by1 = c[7];
		dxa = ax0 - ax1; dya = ay0 - ay1; dxb = bx0 - bx1; dyb = by0 - by1;
		xmina = (ax0 < ax1) ? ax0 : ax1; xmaxa = (ax0 > ax1) ? ax0 : ax1;
		ymina = (ay0 < ay1) ? ay0 : ay1; ymaxa = (ay0 > ay1) ? ay0 : ay1;
		xminb = (bx0 < bx1) ? bx0 : bx1; xmaxb = (bx0 > bx1) ? bx0 : bx1;
		yminb = (by0 < by1) ? by0 : by1; ymaxb = (by0 > by1) ? by0 : by1;
		if (dxa == 0 && dyb == 0) begin
			r.case_taken = CASE_VH;
			r.crosses = (xmaxa < xmaxb && xmaxa > xminb) && (ymaxb < ymaxa && ymaxb > ymina);
		end else if (dya == 0 && dxb == 0) begin
			r.case_taken = CASE_HV;
			r.crosses = (xmaxb < xmaxa && xmaxb > xmina) && (ymaxa < ymaxb && ymaxa > yminb);
		end else if (dxa != 0 && dxb != 0) begin
			r.case_taken = CASE_X;
			r.crosses = crosses_on_axis(ax0, ay0, dxa, dya, bx0, by0, dxb, dyb,
				xmina, xmaxa, xminb, xmaxb);
		end else if (dya != 0 && dyb != 0) begin
			r.case_taken = CASE_Y;
			r.crosses = crosses_on_axis(ay0, ax0, dya, dxa, by0, bx0, dyb, dxb,
				ymina, ymaxa, yminb, ymaxb);
		end else begin
			r.case_taken = CASE_NONE;
			r.crosses = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		crossing_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_crossings = {expected_crossings, predict_crossing(s_axis_tdata)};
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_crossings.size() == 0) begin
					$error("result transfer with no segment pair outstanding");
					fails++;
				end else begin
					want = expected_crossings.pop_front();
					if (m_axis_tdata[0] !== want.crosses) begin
						$error("crosses: expected %0d, actual %0d",
							want.crosses, m_axis_tdata[0]);
						fails++;
					end
					if (m_axis_tdata[3:1] !== want.case_taken) begin
						$error("case_taken: expected %0d, actual %0d",
							want.case_taken, m_axis_tdata[3:1]);
						fails++;
					end
				end
			end
		end
		fail_count <= fails;
		pending    <= expected_crossings.size();
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment intersection test bench
// Drives directed and random segment pairs into the intersection block with
// random gaps and receiver stalls, one long receiver hold-off included, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
	import sit_pkg::*;

	localparam int RANDOM_PAIRS = 1700;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	int                     fail_count;
	int                     pending;
	bit                     flood = 1'b0;
	int                     pair_count = 0;

	segment_intersection_test uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	crossing_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// fields from a_start_x in the lowest bits up to b_end_y
	function automatic logic [IN_TDATA_W-1:0] pack_pair(
		int ax0, int ay0, int ax1, int ay1, int bx0, int by0, int bx1, int by1
	);
		logic [COORD_WIDTH-1:0] f[8];
		logic [IN_TDATA_W-1:0]  d;
		f[0] = COORD_WIDTH'(ax0); f[1] = COORD_WIDTH'(ay0);
		f[2] = COORD_WIDTH'(ax1); f[3] = COORD_WIDTH'(ay1);
		f[4] = COORD_WIDTH'(bx0); f[5] = COORD_WIDTH'(by0);
		f[6] = COORD_WIDTH'(bx1); f[7] = COORD_WIDTH'(by1);
		d = '0;
		for (int i = 0; i < 8; i++)
			d[COORD_WIDTH*i +: COORD_WIDTH] = f[i];
		return d;
	endfunction

	function automatic int pick_coord(int pool);
		int extremes[7];
		extremes = '{-32768, -32767, -1, 0, 1, 32766, 32767};
		case (pool)
			0: return $urandom_range(0, 65535) - 32768;
			1: return ($urandom_range(0, 6) - 3) * (($urandom_range(0, 1) == 1) ? 256 : 1);
			default: return extremes[$urandom_range(0, 6)];
		endcase
	endfunction

	function automatic logic [IN_TDATA_W-1:0] random_pair();
		int c[8];
		int pool;
		int shape;
		int r;
		r = $urandom_range(0, 9);
		pool = (r < 5) ? 0 : (r < 8) ? 1 : 2;
		for (int i = 0; i < 8; i++)
			c[i] = pick_coord(pool);
		shape = $urandom_range(0, 11);
		case (shape)
			// A vertical, B horizontal
			0, 1: begin c[2] = c[0]; c[7] = c[5]; end
			// A horizontal, B vertical
			2, 3: begin c[3] = c[1]; c[6] = c[4]; end
			4: c[2] = c[0];
			5: c[7] = c[5];
			// B parallel to A
			6: begin c[6] = c[4] + c[2] - c[0]; c[7] = c[5] + c[3] - c[1]; end
			// A collapsed to a point
			7: begin c[2] = c[0]; c[3] = c[1]; end
			default: ;
		endcase
		return pack_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endfunction

	// call at a falling edge; returns at the falling edge after the transfer
	task automatic send_pair(input logic [IN_TDATA_W-1:0] d);
		int gap;
		gap = ((pair_count / 150) % 4 == 3 || flood) ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pair_count++;
		@(negedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_pair(pack_pair(0, -100, 0, 100, -100, 50, 100, 50));
		send_pair(pack_pair(100, -100, 100, 100, -100, 50, 100, 50));
		send_pair(pack_pair(-100, 0, 100, 0, 30, -50, 30, 50));
		send_pair(pack_pair(-100, 0, 100, 0, 200, -50, 200, 50));
		send_pair(pack_pair(-100, -100, 100, 100, -100, 100, 100, -100));
		send_pair(pack_pair(100, 100, -100, -100, 100, -100, -100, 100));
		send_pair(pack_pair(0, 0, 100, 100, 0, 10, 100, 110));
		send_pair(pack_pair(0, 0, 100, 100, 50, 50, 150, 150));
		send_pair(pack_pair(0, 0, 10, 10, 100, 0, 90, 10));
		send_pair(pack_pair(0, 0, 100, 100, 50, 50, 100, 0));
		send_pair(pack_pair(0, 0, 100, 0, 0, 5, 100, 5));
		send_pair(pack_pair(0, -100, 0, 100, -50, -50, 50, 50));
		send_pair(pack_pair(0, 0, 0, 100, 10, 0, 10, 100));
		send_pair(pack_pair(5, 5, 5, 5, 0, 0, 10, 20));
		send_pair(pack_pair(3, 3, 3, 3, 3, 3, 3, 3));
		send_pair(pack_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		send_pair(pack_pair(0, -32768, 0, 32767, -32768, 0, 32767, 0));
		send_pair(pack_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
		send_pair(pack_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
		send_pair(pack_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_pair(pack_pair(-21846, 21845, 21845, -21846, 21845, 21845, -21846, -21846));
		send_pair(pack_pair(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845));

		for (int i = 0; i < RANDOM_PAIRS; i++)
			send_pair(random_pair());
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// receiver: random stalls, one long hold-off to back the pipeline up
	initial begin
		int  cycles;
		int  len;
		bit  held;
		cycles = 0;
		held   = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && cycles >= 1000) begin
				m_axis_tready <= 1'b0;
				flood = 1'b1;
				repeat (400) @(negedge clk);
				flood = 1'b0;
				held  = 1'b1;
				cycles += 400;
			end else begin
				len = ($urandom_range(0, 30) == 0) ? 200 : $urandom_range(1, 8);
				m_axis_tready <= 1'b1;
				repeat (len) @(negedge clk);
				cycles += len;
				len = idle_len();
				if (len > 0) begin
					m_axis_tready <= 1'b0;
					repeat (len) @(negedge clk);
					cycles += len;
				end
			end
		end
	end

	initial begin
		#10000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
